/* sv/crc16_checked_telemetry_frame_rx_assert.svh */
// Assertion macros for the telemetry frame receiver.
// Both macros expect clk_i and rst_ni in the scope where they are used.
`ifndef CRC16_CHECKED_TELEMETRY_FRAME_RX_ASSERT_SVH
`define CRC16_CHECKED_TELEMETRY_FRAME_RX_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define CFRX_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("cfrx assertion failed");

// Consequent must hold in the cycle after the antecedent.
`define CFRX_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("cfrx assertion failed");

`endif

/* sv/cfrx_pkg.sv */
// Shared types and constants for the telemetry frame receiver.
// No dependencies; used by every module of the block.
package cfrx_pkg;

  localparam int unsigned MAX_FRAME_DEF = 128;
  localparam int unsigned MIN_FRAME     = 19;

  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'hA001;

  // Byte offsets of the captured fields within a frame.
  localparam int unsigned POS_CUR_HI  = 3;
  localparam int unsigned POS_CUR_LO  = 4;
  localparam int unsigned POS_VOLT_B3 = 5;
  localparam int unsigned POS_VOLT_B2 = 6;
  localparam int unsigned POS_VOLT_B1 = 7;
  localparam int unsigned POS_VOLT_B0 = 8;
  localparam int unsigned POS_PWR_HI  = 9;
  localparam int unsigned POS_PWR_LO  = 10;
  localparam int unsigned POS_STATUS  = 12;
  localparam int unsigned POS_TX_TEMP = 17;
  localparam int unsigned POS_RX_TEMP = 18;

  typedef struct packed {
    logic       frame_end;
    logic [7:0] rx_byte;
  } cfrx_item_t;

  typedef struct packed {
    logic              crc_ok;
    logic              too_short;
    logic [15:0]       current_ma;
    logic [31:0]       voltage_mv;
    logic [15:0]       power_w;
    logic [7:0]        status_code;
    logic signed [7:0] tx_temp;
    logic signed [7:0] rx_temp;
  } cfrx_result_t;

endpackage

/* sv/cfrx_crc16.sv */
// One-byte update of the reflected CRC-16 (polynomial 0xA001).
// Depends on cfrx_pkg for the polynomial.
module cfrx_crc16 (
  input  logic [15:0] crc_i,
  input  logic [7:0]  data_i,
  output logic [15:0] crc_o
);
  import cfrx_pkg::*;

  always_comb begin
    logic [15:0] acc;
    acc = crc_i ^ {8'h00, data_i};
    for (int k = 0; k < 8; k++) begin
      if (acc[0]) begin
        acc = (acc >> 1) ^ CRC_POLY;
      end else begin
        acc = acc >> 1;
      end
    end
    crc_o = acc;
  end

endmodule

/* sv/cfrx_frame_core.sv */
// Frame state: byte counter, CRC accumulator, two-byte delay window and field capture.
// Depends on cfrx_pkg and cfrx_crc16; builds the result for a frame-end byte.
module cfrx_frame_core #(
  parameter int unsigned MAX_FRAME = cfrx_pkg::MAX_FRAME_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  fire_i,
  input  cfrx_pkg::cfrx_item_t  item_i,
  output cfrx_pkg::cfrx_result_t result_o
);
  import cfrx_pkg::*;
  `include "crc16_checked_telemetry_frame_rx_assert.svh"

  localparam int unsigned IdxW = $clog2(MAX_FRAME + 1);

  logic [IdxW-1:0] idx_q, idx_d;
  logic [15:0]     crc_q, crc_d, crc_upd, crc_step;
  logic [7:0]      hold0_q, hold1_q;
  logic [15:0]     cur_q, cur_d;
  logic [31:0]     volt_q, volt_d;
  logic [15:0]     pwr_q, pwr_d;
  logic [7:0]      stat_q, stat_d;
  logic [7:0]      txt_q, txt_d;
  logic [7:0]      rxt_q, rxt_d;
  logic [15:0]     rx_crc;
  logic            short_frame;
  logic [7:0]      b;

  assign b = item_i.rx_byte;

  cfrx_crc16 u_crc (
    .crc_i  (crc_q),
    .data_i (hold0_q),
    .crc_o  (crc_step)
  );

  // The oldest window byte enters the CRC once two bytes are buffered.
  assign crc_upd = (idx_q >= IdxW'(2)) ? crc_step : crc_q;

  always_comb begin
    cur_d  = cur_q;
    volt_d = volt_q;
    pwr_d  = pwr_q;
    stat_d = stat_q;
    txt_d  = txt_q;
    rxt_d  = rxt_q;
    if (idx_q == IdxW'(POS_CUR_HI))  cur_d[15:8]   = b;
    if (idx_q == IdxW'(POS_CUR_LO))  cur_d[7:0]    = b;
    if (idx_q == IdxW'(POS_VOLT_B3)) volt_d[31:24] = b;
    if (idx_q == IdxW'(POS_VOLT_B2)) volt_d[23:16] = b;
    if (idx_q == IdxW'(POS_VOLT_B1)) volt_d[15:8]  = b;
    if (idx_q == IdxW'(POS_VOLT_B0)) volt_d[7:0]   = b;
    if (idx_q == IdxW'(POS_PWR_HI))  pwr_d[15:8]   = b;
    if (idx_q == IdxW'(POS_PWR_LO))  pwr_d[7:0]    = b;
    if (idx_q == IdxW'(POS_STATUS))  stat_d        = b;
    if (idx_q == IdxW'(POS_TX_TEMP)) txt_d         = b;
    if (idx_q == IdxW'(POS_RX_TEMP)) rxt_d         = b;
  end

  // Received CRC travels low byte first: previous byte is low, this byte high.
  assign rx_crc      = {b, hold1_q};
  assign short_frame = idx_q < IdxW'(MIN_FRAME - 1);

  always_comb begin
    result_o           = '0;
    result_o.crc_ok    = (idx_q >= IdxW'(1)) && (rx_crc == crc_upd);
    result_o.too_short = short_frame;
    if (!short_frame) begin
      result_o.current_ma  = cur_d;
      result_o.voltage_mv  = volt_d;
      result_o.power_w     = pwr_d;
      result_o.status_code = stat_d;
      result_o.tx_temp     = txt_d;
      result_o.rx_temp     = rxt_d;
    end
  end

  always_comb begin
    idx_d = idx_q;
    crc_d = crc_q;
    if (fire_i) begin
      if (item_i.frame_end) begin
        idx_d = '0;
        crc_d = CRC_INIT;
      end else begin
        crc_d = crc_upd;
        if (idx_q != IdxW'(MAX_FRAME)) idx_d = idx_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q <= '0;
      crc_q <= CRC_INIT;
    end else begin
      idx_q <= idx_d;
      crc_q <= crc_d;
    end
  end

  // Window and captures are always rewritten before a long frame uses them.
  always_ff @(posedge clk_i) begin
    if (fire_i) begin
      hold0_q <= hold1_q;
      hold1_q <= b;
      cur_q   <= cur_d;
      volt_q  <= volt_d;
      pwr_q   <= pwr_d;
      stat_q  <= stat_d;
      txt_q   <= txt_d;
      rxt_q   <= rxt_d;
    end
  end

  `CFRX_ASSERT_NEXT(a_idx_clear, fire_i && item_i.frame_end, idx_q == '0)
  `CFRX_ASSERT_NEXT(a_crc_clear, fire_i && item_i.frame_end, crc_q == CRC_INIT)
  `CFRX_ASSERT_NEXT(a_idx_step,
      fire_i && !item_i.frame_end && (idx_q != IdxW'(MAX_FRAME)),
      idx_q == IdxW'($past(idx_q) + 1'b1))

endmodule

/* sv/crc16_checked_telemetry_frame_rx.sv */
// Top level of the CRC-16 checked telemetry frame receiver.
// Depends on cfrx_pkg, cfrx_frame_core and cfrx_crc16.

// The block takes one received byte per transaction on the slave stream, with
// tlast on the final byte of a frame, and returns one result transaction per
// frame. The CRC (init 0xFFFF, reflected polynomial 0xA001) covers every byte
// but the last two, which are compared as the received CRC, low byte first.
// Fields are taken big-endian from fixed offsets: current from bytes 3-4,
// voltage from 5-8, power from 9-10, status from 12, signed temperatures from
// 17 (transmitter) and 18 (receiver). A frame of fewer than 19 bytes sets
// too_short and zeroes all fields; a one-byte frame never reports crc_ok.
// The byte counter saturates at MAX_FRAME without disturbing CRC or capture.
// Rate: one byte per clock cycle unless stalled, set by the combinational CRC
// byte update between the input and result registers. The last byte of a frame
// passes both registers before its result is valid. Input stalls only while
// a frame-end byte waits for the result register to be taken.
module crc16_checked_telemetry_frame_rx #(
  parameter int unsigned MAX_FRAME = cfrx_pkg::MAX_FRAME_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [7:0]  s_axis_tdata_i,   // [7:0] rx_byte
  input  logic        s_axis_tlast_i,   // frame_end
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [87:0] m_axis_tdata_o,   // [15:0] current_ma, [47:16] voltage_mv,
                                        // [63:48] power_w, [71:64] status_code,
                                        // [79:72] tx_temp, [87:80] rx_temp
  output logic [1:0]  m_axis_tuser_o    // [0] crc_ok, [1] too_short
);
  import cfrx_pkg::*;
  `include "crc16_checked_telemetry_frame_rx_assert.svh"

  logic         in_valid_q, in_valid_d;
  cfrx_item_t   in_item_q;
  logic         out_valid_q, out_valid_d;
  cfrx_result_t out_res_q;
  cfrx_result_t core_res;
  logic         out_free;
  logic         proc_fire;

  // Result register is free when empty or its transaction completes now.
  assign out_free  = !out_valid_q || m_axis_tready_i;
  // Non-final bytes produce no result and never wait on the output side.
  assign proc_fire = in_valid_q && (!in_item_q.frame_end || out_free);
  assign s_axis_tready_o = !in_valid_q || proc_fire;

  cfrx_frame_core #(
    .MAX_FRAME (MAX_FRAME)
  ) u_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .fire_i   (proc_fire),
    .item_i   (in_item_q),
    .result_o (core_res)
  );

  always_comb begin
    in_valid_d = in_valid_q;
    if (s_axis_tready_o) in_valid_d = s_axis_tvalid_i;
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (proc_fire && in_item_q.frame_end) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Load input per accepted byte, result per fired frame end; else hold.
  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid_i && s_axis_tready_o) begin
      in_item_q.rx_byte   <= s_axis_tdata_i;
      in_item_q.frame_end <= s_axis_tlast_i;
    end
    if (proc_fire && in_item_q.frame_end) begin
      out_res_q <= core_res;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {out_res_q.rx_temp, out_res_q.tx_temp, out_res_q.status_code,
                            out_res_q.power_w, out_res_q.voltage_mv, out_res_q.current_ma};
  assign m_axis_tuser_o  = {out_res_q.too_short, out_res_q.crc_ok};

  `CFRX_ASSERT_NOW(a_ready_when_empty, !in_valid_q, s_axis_tready_o)
  `CFRX_ASSERT_NOW(a_stall_on_full_out,
      in_valid_q && in_item_q.frame_end && m_axis_tvalid_o && !m_axis_tready_i,
      !s_axis_tready_o)
  `CFRX_ASSERT_NEXT(a_result_follows_end, proc_fire && in_item_q.frame_end,
      m_axis_tvalid_o)

endmodule
